// ===== design/sliding_window_min_max_mean_core_assert.svh =====
// assertion macros for the sliding window core
`ifndef SLIDING_WINDOW_MIN_MAX_MEAN_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_MEAN_CORE_ASSERT_SVH

// implication checked on every clock edge out of reset
`define SWM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// shared types and constants of the sliding window min / max / mean core
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int LEN_W      = PTR_W + 1;
  localparam int SUM_W      = 32 + LEN_W;
  localparam int SAMPLE_W   = 32;
  localparam int IDX_W      = 16;
  localparam int CFG_AW     = 3;

  localparam logic [CFG_AW-1:0] REG_WINDOW_LEN = 3'd0;
  localparam logic [LEN_W-1:0]  LEN_RESET      = LEN_W'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OLD,
    ST_SCAN,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       new_series;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] window_max;
    logic signed [SAMPLE_W-1:0] window_min;
    logic signed [SAMPLE_W-1:0] window_mean;
    logic [IDX_W-1:0]           window_index;
  } out_beat_t;

endpackage

// ===== design/swm_if.sv =====
// ----------------------------------------------------------------------------
// swm_stream_if
// valid / ready channel carrying one beat of a generic payload type
// ----------------------------------------------------------------------------
interface swm_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/sliding_window_min_max_mean_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean_core
// windowed max, min and truncated mean over a stream of Q16.16 samples
// ----------------------------------------------------------------------------
// channel | dir | payload
// in      | in  | sample, new_series
// out     | out | window_max, window_min, window_mean, window_index
// cfg     | in  | APB write/read of window_len at address 0
//
// one sample at a time through a sample memory with a registered read
// a full window runs through accept, update, the scan over the window, the
// divide and the output load before the next ready; a filling window goes back
// to idle after the update; the scan reads one memory entry a cycle
// output held in a register while out_ready is low; the next full window
// waits for it before loading, filling samples are still taken in
// no clearing pass: only entries written in the current series are read
`include "sliding_window_min_max_mean_core_assert.svh"

module sliding_window_min_max_mean_core
  import swm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  swm_stream_if.sink          in_ch,
  swm_stream_if.source        out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic [PTR_W-1:0]           rd_addr;
  logic                       wr_en;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]           len_reg_r;
  logic [PTR_W-1:0]           wp_r;
  logic [LEN_W-1:0]           fill_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [IDX_W-1:0]           wcnt_r;
  logic signed [SAMPLE_W-1:0] samp_r;
  logic                       drop_r;
  logic [LEN_W-1:0]           cnt_r;
  logic [PTR_W-1:0]           scan_ptr_r;
  logic signed [SAMPLE_W-1:0] mx_r, mn_r;
  logic                       out_valid_r;
  out_beat_t                  out_r;

  // restoring divider on the magnitude
  logic [SUM_W-1:0]           quo_r;
  logic [LEN_W:0]             rem_r;
  logic                       neg_r;
  logic [LEN_W:0]             rem_try;

  logic [LEN_W-1:0] len_eff;
  logic             cfg_wr;
  logic             cfg_sel_len;
  logic             in_acc;

  assign len_eff = (len_reg_r == '0) ? LEN_W'(1) :
                   (len_reg_r > LEN_W'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW) : len_reg_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel_len = (cfg_paddr[CFG_AW-1:2] == REG_WINDOW_LEN[CFG_AW-1:2]);
  assign cfg_prdata = cfg_sel_len ? 32'(len_reg_r) : 32'd0;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // oldest sample sits len_eff entries behind the write pointer
  always_comb begin
    rd_addr = scan_ptr_r;
    if (state_r == ST_IDLE) rd_addr = wp_r - len_eff[PTR_W-1:0];
  end
  assign wr_en = (state_r == ST_OLD);

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (wr_en) mem[wp_r] <= samp_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_OLD;
      ST_OLD: begin
        // window still filling after this sample
        if (!drop_r && (fill_r + LEN_W'(1) < len_eff)) state_nxt = ST_IDLE;
        else state_nxt = ST_SCAN;
      end
      ST_SCAN: if (cnt_r == '0) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == '0) state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign rem_try = {rem_r[LEN_W-1:0], quo_r[SUM_W-1]} - {1'b0, len_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_reg_r   <= LEN_RESET;
      wp_r        <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      wcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_wr && cfg_sel_len) begin
        len_reg_r <= cfg_pwdata[LEN_W-1:0];
        fill_r    <= '0;
        sum_r     <= '0;
        wcnt_r    <= '0;
      end
      case (state_r)
        ST_IDLE: if (in_acc) begin
          samp_r <= in_ch.data.sample;
          if (in_ch.data.new_series) begin
            fill_r <= '0;
            sum_r  <= '0;
            wcnt_r <= '0;
            drop_r <= 1'b0;
          end else begin
            drop_r <= (fill_r >= len_eff);
          end
        end
        ST_OLD: begin
          // rd_data_r holds the oldest sample of the full window
          sum_r  <= sum_r + SUM_W'(samp_r) - (drop_r ? SUM_W'(rd_data_r) : '0);
          fill_r <= drop_r ? len_eff : fill_r + LEN_W'(1);
          wp_r   <= wp_r + PTR_W'(1);
          mx_r   <= samp_r;
          mn_r   <= samp_r;
          scan_ptr_r <= wp_r - PTR_W'(1);
          cnt_r  <= len_eff - LEN_W'(1);
        end
        ST_SCAN: begin
          // the first scan read was issued in ST_OLD from the stale scan_ptr_r, so it is skipped
          if (cnt_r != len_eff - LEN_W'(1)) begin
            if (rd_data_r > mx_r) mx_r <= rd_data_r;
            if (rd_data_r < mn_r) mn_r <= rd_data_r;
          end
          if (cnt_r != '0) begin
            scan_ptr_r <= scan_ptr_r - PTR_W'(1);
            cnt_r      <= cnt_r - LEN_W'(1);
          end else begin
            neg_r <= sum_r[SUM_W-1];
            quo_r <= sum_r[SUM_W-1] ? -sum_r : sum_r;
            rem_r <= '0;
            cnt_r <= LEN_W'(SUM_W - 1);
          end
        end
        ST_DIV: begin
          if (rem_try[LEN_W]) begin
            rem_r <= {rem_r[LEN_W-1:0], quo_r[SUM_W-1]};
            quo_r <= {quo_r[SUM_W-2:0], 1'b0};
          end else begin
            rem_r <= rem_try;
            quo_r <= {quo_r[SUM_W-2:0], 1'b1};
          end
          cnt_r <= cnt_r - LEN_W'(1);
        end
        ST_OUT: if (!out_valid_r) begin
          out_valid_r         <= 1'b1;
          out_r.window_max    <= mx_r;
          out_r.window_min    <= mn_r;
          out_r.window_mean   <= neg_r ? -quo_r[SAMPLE_W-1:0] : quo_r[SAMPLE_W-1:0];
          out_r.window_index  <= wcnt_r;
          wcnt_r              <= wcnt_r + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  `SWM_ASSERT_IMP(a_fill_bound, state_r == ST_IDLE, fill_r <= len_eff,
                  "fill count beyond window length")
  `SWM_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ch.ready,
                   out_valid_r && $stable(out_r), "result beat dropped")
  `SWM_ASSERT_IMP(a_no_accept_busy, state_r != ST_IDLE, !in_ch.ready,
                  "beat accepted while busy")

endmodule

// ===== bench/sliding_window_min_max_mean_core_tb.sv =====
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean_core_tb
// drives Q16.16 samples through the core across several window lengths and
// checks every window max, min, mean and index against a local predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_min_max_mean_core_tb;
  import swm_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  swm_stream_if #(.payload_t(in_beat_t))  in_ch ();
  swm_stream_if #(.payload_t(out_beat_t)) out_ch ();

  sliding_window_min_max_mean_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predictor state
  logic signed [31:0] hist [MAX_WINDOW];
  int unsigned        wr_ptr;
  int unsigned        fill;
  longint             win_sum;
  logic [15:0]        win_cnt;
  logic [8:0]         len_reg;

  out_beat_t window_q [$];
  int  errors;
  int  n_results;
  int  n_samples;
  int  send_idle_pct;
  int  recv_stall_pct;

  initial clk = 1'b0;

  always #5 clk = ~clk;

  function automatic int unsigned eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > MAX_WINDOW) return MAX_WINDOW;
    return len_reg;
  endfunction

  function automatic void restart_window();
    fill    = 0;
    win_sum = 0;
    win_cnt = '0;
  endfunction

  function automatic void predict_window(in_beat_t b);
    int unsigned n;
    out_beat_t   r;
    logic signed [31:0] v;
    n = eff_len();
    if (b.new_series) restart_window();
    if (fill >= n) begin
      win_sum -= hist[(wr_ptr + MAX_WINDOW - n) % MAX_WINDOW];
      fill = n - 1;
    end
    hist[wr_ptr] = b.sample;
    win_sum += b.sample;
    fill++;
    wr_ptr = (wr_ptr + 1) % MAX_WINDOW;
    if (fill < n) return;
    r.window_max = b.sample;
    r.window_min = b.sample;
    for (int k = 1; k <= n; k++) begin
      v = hist[(wr_ptr + MAX_WINDOW - k) % MAX_WINDOW];
      if (v > r.window_max) r.window_max = v;
      if (v < r.window_min) r.window_min = v;
    end
    r.window_mean  = 32'(win_sum / longint'(n));
    r.window_index = win_cnt;
    win_cnt++;
    window_q.push_back(r);
  endfunction

  // receiver with random stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (window_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = window_q.pop_front();
        if (out_ch.data.window_max !== e.window_max) begin
          $error("window_max exp %0d got %0d", e.window_max, out_ch.data.window_max);
          errors++;
        end
        if (out_ch.data.window_min !== e.window_min) begin
          $error("window_min exp %0d got %0d", e.window_min, out_ch.data.window_min);
          errors++;
        end
        if (out_ch.data.window_mean !== e.window_mean) begin
          $error("window_mean exp %0d got %0d", e.window_mean, out_ch.data.window_mean);
          errors++;
        end
        if (out_ch.data.window_index !== e.window_index) begin
          $error("window_index exp %0d got %0d", e.window_index,
                 out_ch.data.window_index);
          errors++;
        end
      end
    end
  end

  task automatic send_sample(logic signed [31:0] s, logic ns);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.data       <= '{sample: s, new_series: ns};
    do @(posedge clk); while (!in_ch.ready);
    predict_window('{sample: s, new_series: ns});
    n_samples++;
    in_ch.valid <= 1'b0;
    // the core is busy on the cycle after an accepted beat
    @(posedge clk);
  endtask

  task automatic drain();
    while (window_q.size() != 0) @(posedge clk);
    // a filling sample or a trailing scan may still be in flight
    repeat (MAX_WINDOW + 60) @(posedge clk);
  endtask

  task automatic write_len(logic [31:0] val);
    drain();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_WINDOW_LEN;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    len_reg = val[8:0];
    restart_window();
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(65535)) - 32'd32768);
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // reset length of 16, extremes and a mid-series restart
    for (int i = 0; i < 18; i++)
      send_sample(i[0] ? 32'sh7fff_ffff : 32'sh8000_0000, 1'b0);
    send_sample(32'sh0001_0000, 1'b1);
    write_len(32'd1);
    send_sample(-32'sd3, 1'b0);
    send_sample(32'sd5, 1'b0);
    write_len(32'd0);     // zero acts as one
    send_sample(-32'sd7, 1'b1);
    write_len(32'h1ff);   // saturates at max window
    for (int i = 0; i < 3; i++) send_sample(32'sh7fff_ffff, 1'b0);
  endtask

  task automatic run_random(int count, int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++)
      send_sample(rand_sample(), $urandom_range(39) == 0);
  endtask

  task automatic test_random();
    write_len(32'd3);
    run_random(200, 0, 0);
    write_len(32'd256);
    run_random(300, 0, 0);
    write_len(32'd7);
    run_random(150, 71, 0);
    // hold off until every expected window has been received
    while (window_q.size() != 0) @(posedge clk);
    write_len(32'd2);
    run_random(150, 0, 71);
    write_len(32'd1);
    run_random(150, 17, 17);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    errors = 0; n_results = 0; n_samples = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    wr_ptr  = 0;
    len_reg = LEN_RESET;
    restart_window();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    $display("%0d samples sent over window lengths 0..511, %0d windows checked",
             n_samples, n_results);
    if (errors == 0 && window_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
